FILE: sv/tprl_pkg.sv
// Shared types, constants and codes for the three-phase R-L start-up simulator.
package tprl_pkg;

   localparam int NUM_PHASES_DEF = 3;
   localparam int PHASE_SLOTS    = 3;
   localparam int ACC_W          = 88;

   localparam int TIME_STEP_W = 24;
   localparam int RES_W       = 32;
   localparam int INV_IND_W   = 36;
   localparam int DURATION_W  = 40;
   localparam int CSR_DATA_W  = 40;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESISTANCE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_INDUCTANCE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_DURATION = 2'd3;

   localparam logic [TIME_STEP_W-1:0] TIME_STEP_RST = 24'd4295;
   localparam logic [RES_W-1:0]       RES_RST       = 32'd65536;
   localparam logic [INV_IND_W-1:0]   INV_IND_RST   = 36'd256000;
   localparam logic [DURATION_W-1:0]  DURATION_RST  = 40'd429496730;

   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_C = 2'd2;

   localparam logic [47:0] FLUX_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] FLUX_MIN = 48'h8000_0000_0000;
   localparam logic [23:0] CUR_MAX  = 24'h7F_FFFF;
   localparam logic [23:0] CUR_MIN  = 24'h80_0000;

   typedef struct packed {
      logic               start_enable;
      logic signed [23:0] volt_a_first;
      logic signed [23:0] volt_a_second;
      logic signed [23:0] volt_b_first;
      logic signed [23:0] volt_b_second;
      logic signed [23:0] volt_c_first;
      logic signed [23:0] volt_c_second;
   } req_type;

   typedef struct packed {
      logic signed [23:0] amp_a;
      logic signed [23:0] amp_b;
      logic signed [23:0] amp_c;
      logic [2:0]         active_phases;
   } rsp_type;

   typedef struct packed {
      logic [TIME_STEP_W-1:0] time_step;
      logic [RES_W-1:0]       resistance;
      logic [INV_IND_W-1:0]   inverse_inductance;
      logic [DURATION_W-1:0]  start_duration;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_R_CUR,
      OP_TL_DT,
      OP_TH_DT,
      OP_FL_IL,
      OP_FL_IH,
      OP_FH_IL,
      OP_FH_IH
   } mul_op_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_32,
      SH_64
   } mul_shift_type;

   typedef enum logic [1:0] {
      INIT_NONE,
      INIT_DIFF,
      INIT_HALF32,
      INIT_HALF24
   } acc_init_type;

   typedef struct packed {
      logic          accept;
      logic [1:0]    phase;
      logic          phase_clr;
      logic          mul_en;
      mul_op_type    mul_op;
      mul_shift_type mul_shift;
      acc_init_type  acc_init;
      logic          term_load;
      logic          flux_wr;
      logic          cur_wr;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic [PHASE_SLOTS-1:0] active;
   } status_type;

endpackage

FILE: sv/three_phase_rl_startup_simulator_core.sv
// Top level of the three-phase R-L start-up simulator: CSRs, sequencer and datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  tprl_pkg::req_type (enable, six voltages)
//   rsp_      out        rsp_valid / rsp_stall  tprl_pkg::rsp_type (three currents, phases)
//   csr_      in         csr_write              csr_index, csr_wdata (no read-back)
//
// For an engaged beat, one shared 33x33 multiplier runs 7 products per connected phase
// over 12 sequencer steps, for 3 phases, then the result is loaded in the done state.
// A beat with no phase connected (enable low or duration reached) runs no products
// and clears each phase's flux and current.
// Reset (synchronous) loads the CSR defaults and zeroes fluxes, currents and the timer.
// req_stall is high while a beat is in work; a finished result waits in the output
// register and the next beat is accepted while rsp_stall holds it.
module three_phase_rl_startup_simulator_core #(
   parameter int NUM_PHASES = tprl_pkg::NUM_PHASES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tprl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tprl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [tprl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tprl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tprl_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register bank; to be written only while no beat is in work
   tprl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: owns both handshakes and the step counter
   tprl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   tprl_dp #(
      .NUM_PHASES (NUM_PHASES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: sv/tprl_csr.sv
// Configuration register bank: step, resistance, inverse inductance, duration.
module tprl_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [tprl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tprl_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output tprl_pkg::cfg_type                     cfg
);
   import tprl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TIME_STEP:      cfg_in.time_step          = csr_wdata[TIME_STEP_W-1:0];
            CSR_RESISTANCE:     cfg_in.resistance         = csr_wdata[RES_W-1:0];
            CSR_INV_INDUCTANCE: cfg_in.inverse_inductance = csr_wdata[INV_IND_W-1:0];
            CSR_START_DURATION: cfg_in.start_duration     = csr_wdata[DURATION_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step          <= TIME_STEP_RST;
         cfg_ff.resistance         <= RES_RST;
         cfg_ff.inverse_inductance <= INV_IND_RST;
         cfg_ff.start_duration     <= DURATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/tprl_ctrl.sv
// Sequencer: steps the shared multiplier through each phase and runs both handshakes.
module tprl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tprl_pkg::status_type status,
   output tprl_pkg::cmd_type    cmd
);
   import tprl_pkg::*;

   localparam logic [3:0] STEP_DRIVE = 4'd0;
   localparam logic [3:0] STEP_TERM  = 4'd2;
   localparam logic [3:0] STEP_TH    = 4'd3;
   localparam logic [3:0] STEP_FLUX  = 4'd5;
   localparam logic [3:0] STEP_FLIL  = 4'd6;
   localparam logic [3:0] STEP_FLIH  = 4'd7;
   localparam logic [3:0] STEP_FHIL  = 4'd8;
   localparam logic [3:0] STEP_FHIH  = 4'd9;
   localparam logic [3:0] STEP_LAST  = 4'd11;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [3:0]     step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_A;
         step_ff      <= STEP_DRIVE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      logic advance;
      advance   = 1'b0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.phase = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RUN;
               phase_in   = PH_A;
               step_in    = STEP_DRIVE;
            end
         end
         ST_RUN: begin
            if (!status.active[phase_ff]) begin
               cmd.phase_clr = 1'b1;
               advance       = 1'b1;
            end else begin
               step_in = step_ff + 4'd1;
               case (step_ff)
                  STEP_DRIVE: begin
                     cmd.acc_init = INIT_DIFF;
                     cmd.mul_en   = 1'b1;
                     cmd.mul_op   = OP_R_CUR;
                  end
                  STEP_TERM: begin
                     cmd.term_load = 1'b1;
                     cmd.acc_init  = INIT_HALF32;
                     cmd.mul_en    = 1'b1;
                     cmd.mul_op    = OP_TL_DT;
                  end
                  STEP_TH: begin
                     cmd.mul_en    = 1'b1;
                     cmd.mul_op    = OP_TH_DT;
                     cmd.mul_shift = SH_32;
                  end
                  STEP_FLUX: cmd.flux_wr = 1'b1;
                  STEP_FLIL: begin
                     cmd.acc_init = INIT_HALF24;
                     cmd.mul_en   = 1'b1;
                     cmd.mul_op   = OP_FL_IL;
                  end
                  STEP_FLIH: begin
                     cmd.mul_en    = 1'b1;
                     cmd.mul_op    = OP_FL_IH;
                     cmd.mul_shift = SH_32;
                  end
                  STEP_FHIL: begin
                     cmd.mul_en    = 1'b1;
                     cmd.mul_op    = OP_FH_IL;
                     cmd.mul_shift = SH_32;
                  end
                  STEP_FHIH: begin
                     cmd.mul_en    = 1'b1;
                     cmd.mul_op    = OP_FH_IH;
                     cmd.mul_shift = SH_64;
                  end
                  STEP_LAST: begin
                     cmd.cur_wr = 1'b1;
                     advance    = 1'b1;
                  end
                  default: ;
               endcase
            end
            if (advance) begin
               step_in = STEP_DRIVE;
               if (phase_ff == PH_C) begin
                  state_in = ST_DONE;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_DONE: begin
            // old beat leaves on this edge if not stalled
            cmd.out_load = !rsp_valid_ff || !rsp_stall;
            if (cmd.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> phase_ff != 2'd3)
      else $error("phase counter out of range");
   a_step_needs_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff != STEP_DRIVE) |-> status.active[phase_ff])
      else $error("sequencer running on a disconnected phase");
`endif

endmodule

FILE: sv/tprl_dp.sv
// Datapath: timer, per-phase flux and current, shared 33x33 multiplier and accumulator.
module tprl_dp #(
   parameter int NUM_PHASES = tprl_pkg::NUM_PHASES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tprl_pkg::req_type    req_data,
   input  tprl_pkg::cfg_type    cfg,
   input  tprl_pkg::cmd_type    cmd,
   output tprl_pkg::status_type status,
   output tprl_pkg::rsp_type    rsp_data
);
   import tprl_pkg::*;

   localparam logic [PHASE_SLOTS-1:0] PHASE_MASK =
      PHASE_SLOTS'((1 << NUM_PHASES) - 1);

   req_type                 req_ff;
   rsp_type                 rsp_ff;
   logic [DURATION_W-1:0]   elapsed_ff, elapsed_in;
   logic [PHASE_SLOTS-1:0]  active_ff, active_in;
   logic signed [47:0]      flux_ff [PHASE_SLOTS];
   logic signed [23:0]      cur_ff  [PHASE_SLOTS];
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [25:0]      term_hi_ff;
   logic signed [65:0]      prod_ff, prod_in;
   mul_shift_type           shift_ff;
   logic                    pend_ff;

   logic signed [23:0]      v1, v2;
   logic signed [24:0]      diff;
   logic signed [47:0]      flux_sel, flux_upd;
   logic signed [23:0]      cur_sel, cur_upd;
   logic signed [32:0]      mul_a, mul_b;
   logic [ACC_W-1:0]        prod_ext, prod_sh;
   logic signed [56:0]      flux_sum;
   logic [63:0]             cur_q;
   logic [DURATION_W:0]     timer_sum;

   // timer and connection decision, taken as the item is accepted
   always_comb begin
      timer_sum  = {1'b0, elapsed_ff} + {{(DURATION_W-TIME_STEP_W+1){1'b0}}, cfg.time_step};
      elapsed_in = elapsed_ff;
      active_in  = active_ff;
      if (cmd.accept) begin
         if (!req_data.start_enable) begin
            elapsed_in = '0;
            active_in  = '0;
         end else if (timer_sum >= {1'b0, cfg.start_duration}) begin
            elapsed_in = cfg.start_duration;
            active_in  = '0;
         end else begin
            elapsed_in = timer_sum[DURATION_W-1:0];
            active_in  = PHASE_MASK;
         end
      end
   end

   always_comb begin
      case (cmd.phase)
         PH_A: begin
            v1 = req_ff.volt_a_first;
            v2 = req_ff.volt_a_second;
         end
         PH_B: begin
            v1 = req_ff.volt_b_first;
            v2 = req_ff.volt_b_second;
         end
         default: begin
            v1 = req_ff.volt_c_first;
            v2 = req_ff.volt_c_second;
         end
      endcase
      diff     = {v1[23], v1} - {v2[23], v2};
      flux_sel = flux_ff[cmd.phase];
      cur_sel  = cur_ff[cmd.phase];
   end

   // operand selection; unsigned operands zero-extended to 33 bits
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         OP_R_CUR: begin
            mul_a = -{{9{cur_sel[23]}}, cur_sel};
            mul_b = {1'b0, cfg.resistance};
         end
         OP_TL_DT: begin
            mul_a = {1'b0, acc_ff[31:0]};
            mul_b = {9'b0, cfg.time_step};
         end
         OP_TH_DT: begin
            mul_a = {{7{term_hi_ff[25]}}, term_hi_ff};
            mul_b = {9'b0, cfg.time_step};
         end
         OP_FL_IL: begin
            mul_a = {1'b0, flux_sel[31:0]};
            mul_b = {1'b0, cfg.inverse_inductance[31:0]};
         end
         OP_FL_IH: begin
            mul_a = {1'b0, flux_sel[31:0]};
            mul_b = {29'b0, cfg.inverse_inductance[35:32]};
         end
         OP_FH_IL: begin
            mul_a = {{17{flux_sel[47]}}, flux_sel[47:32]};
            mul_b = {1'b0, cfg.inverse_inductance[31:0]};
         end
         OP_FH_IH: begin
            mul_a = {{17{flux_sel[47]}}, flux_sel[47:32]};
            mul_b = {29'b0, cfg.inverse_inductance[35:32]};
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // accumulator: preload, or add last cycle's product at its weight
   always_comb begin
      prod_ext = {{(ACC_W-66){prod_ff[65]}}, prod_ff};
      case (shift_ff)
         SH_32:   prod_sh = {prod_ext[ACC_W-33:0], 32'b0};
         SH_64:   prod_sh = {prod_ext[ACC_W-65:0], 64'b0};
         default: prod_sh = prod_ext;
      endcase
      case (cmd.acc_init)
         INIT_DIFF:   acc_in = {{(ACC_W-41){diff[24]}}, diff, 16'b0};
         INIT_HALF32: acc_in = {{(ACC_W-32){1'b0}}, 1'b1, 31'b0};
         INIT_HALF24: acc_in = {{(ACC_W-24){1'b0}}, 1'b1, 23'b0};
         default:     acc_in = pend_ff ? acc_ff + prod_sh : acc_ff;
      endcase
   end

   // flux += delta with 48-bit saturation; current from rounded product, 24-bit saturation
   always_comb begin
      flux_sum = {{9{flux_sel[47]}}, flux_sel} + {acc_ff[ACC_W-1], acc_ff[ACC_W-1:32]};
      if (flux_sum[56:47] == {10{flux_sum[56]}}) begin
         flux_upd = flux_sum[47:0];
      end else begin
         flux_upd = flux_sum[56] ? FLUX_MIN : FLUX_MAX;
      end
      cur_q = acc_ff[ACC_W-1:24];
      if (cur_q[63:23] == {41{cur_q[63]}}) begin
         cur_upd = cur_q[23:0];
      end else begin
         cur_upd = cur_q[63] ? CUR_MIN : CUR_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         active_ff  <= '0;
         pend_ff    <= 1'b0;
         for (int i = 0; i < PHASE_SLOTS; i++) begin
            flux_ff[i] <= '0;
            cur_ff[i]  <= '0;
         end
      end else begin
         elapsed_ff <= elapsed_in;
         active_ff  <= active_in;
         pend_ff    <= cmd.mul_en;
         if (cmd.phase_clr) begin
            flux_ff[cmd.phase] <= '0;
            cur_ff[cmd.phase]  <= '0;
         end
         if (cmd.flux_wr) begin
            flux_ff[cmd.phase] <= flux_upd;
         end
         if (cmd.cur_wr) begin
            cur_ff[cmd.phase] <= cur_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.term_load) begin
         term_hi_ff <= acc_ff[57:32];
      end
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      shift_ff <= cmd.mul_shift;
      if (cmd.out_load) begin
         rsp_ff.amp_a         <= cur_ff[PH_A];
         rsp_ff.amp_b         <= cur_ff[PH_B];
         rsp_ff.amp_c         <= cur_ff[PH_C];
         rsp_ff.active_phases <= active_ff;
      end
   end

   assign status.active = active_ff;
   assign rsp_data      = rsp_ff;

`ifndef ASSERT_OFF
   a_init_vs_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> cmd.acc_init == INIT_NONE)
      else $error("accumulator preload would drop a pending product");
   a_settled_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.flux_wr || cmd.cur_wr) |-> !pend_ff)
      else $error("flux or current written from an unsettled accumulator");
`endif

endmodule
